FILE: rtl/escseq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escseq_pkg
// Shared types and constants for the control-sequence capture block.
// ----------------------------------------------------------------------------
package escseq_pkg;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_POP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_OUT,
    S_EMIT_OUT,
    S_END_OUT,
    S_FLUSH
  } state_t;

  localparam logic       KIND_POP       = 1'b0;
  localparam logic       KIND_SEQ       = 1'b1;
  localparam logic [7:0] BEGIN_MARK_RST = 8'h9B;

endpackage
`default_nettype wire

FILE: rtl/escape_sequence_capture_with_typeahead.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escape_sequence_capture_with_typeahead
// Console byte stream splitter: plain bytes go to a type-ahead ring FIFO,
// an armed control sequence is collected and emitted as one burst of items.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  -----------------------------------------
//  in_      in   in_valid/in_ready    op, data, term_byte
//  out_     out  out_valid/out_ready  kind, byte_out, last, fifo_was_empty,
//                                     seq_overflow
//  cfg_     in   cfg_wr_en (no wait)  wr_data -> begin mark
//
//  Arm, typed byte and sequence store finish in the idle state; a pop does one
//  FIFO RAM read. An end mark emits the stored sequence bytes, then the end
//  mark; a repeated begin mark flushes them to the FIFO. The sequence RAM gives
//  one byte per cycle while the output is not stalled; an output stall holds
//  the sequencer in its output state; in_ready is high only while idle. Reset
//  clears pointers, counters and phase; undefined RAM data is never output.
// ----------------------------------------------------------------------------
module escape_sequence_capture_with_typeahead #(
  parameter int FIFO_DEPTH = 64,
  parameter int SEQ_DEPTH  = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input items
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_op,
  input  wire logic [7:0] in_data,
  input  wire logic [7:0] in_term_byte,
  // result items
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_kind,
  output logic      [7:0] out_byte_out,
  output logic            out_last,
  output logic            out_fifo_was_empty,
  output logic            out_seq_overflow,
  // begin-mark register
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);
  import escseq_pkg::*;

  localparam int FAW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);
  localparam int SAW = $clog2(SEQ_DEPTH);
  localparam int SLW = $clog2(SEQ_DEPTH + 1);

  // Sequencer and architectural state
  state_t         state_r, state_nxt;
  phase_t         phase_r, phase_nxt;
  logic [FAW-1:0] fifo_head_r, fifo_head_nxt;
  logic [FCW-1:0] fifo_count_r, fifo_count_nxt;
  logic [SLW-1:0] seq_len_r, seq_len_nxt;
  logic [SLW-1:0] idx_r, idx_nxt;
  logic [7:0]     wanted_end_r, wanted_end_nxt;
  logic           ovf_r, ovf_nxt;
  logic [7:0]     begin_mark_r;

  // Output register
  logic       out_valid_r;
  logic       out_kind_r, out_last_r, out_empty_r, out_ovf_r;
  logic [7:0] out_byte_r;
  logic       out_load;
  logic       o_kind, o_last, o_empty, o_ovf;
  logic [7:0] o_byte;
  logic       slot_free;

  // RAM and pointer unit hookups
  logic           push_en;
  logic [7:0]     push_data;
  logic           fifo_we, fifo_re;
  logic [FAW-1:0] fifo_waddr;
  logic [7:0]     fifo_rdata;
  logic           seq_we, seq_re;
  logic [SAW-1:0] seq_waddr, seq_raddr;
  logic [7:0]     seq_wdata, seq_rdata;
  logic           adv_one;
  logic [FCW-1:0] ptr_offs;
  logic [FAW-1:0] ptr_sum;
  logic [SLW-1:0] idx_inc;
  logic           fifo_full;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign idx_inc   = idx_r + 1'b1;
  assign fifo_full = (fifo_count_r >= FCW'(FIFO_DEPTH));

  // One adder serves both the push address (head + count) and the pop advance.
  assign ptr_offs = adv_one ? FCW'(1) : fifo_count_r;

  escseq_wrap_add #(
    .DEPTH (FIFO_DEPTH)
  ) u_ptr (
    .base (fifo_head_r),
    .offs (ptr_offs),
    .sum  (ptr_sum)
  );

  // Drop pushes into a full FIFO.
  assign fifo_we    = push_en && !fifo_full;
  assign fifo_waddr = ptr_sum;

  escseq_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (push_data),
    .re    (fifo_re),
    .raddr (fifo_head_r),
    .rdata (fifo_rdata)
  );

  escseq_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk   (clk),
    .we    (seq_we),
    .waddr (seq_waddr),
    .wdata (seq_wdata),
    .re    (seq_re),
    .raddr (seq_raddr),
    .rdata (seq_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state and datapath controls
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    fifo_head_nxt  = fifo_head_r;
    fifo_count_nxt = fifo_count_r;
    seq_len_nxt    = seq_len_r;
    idx_nxt        = idx_r;
    wanted_end_nxt = wanted_end_r;
    ovf_nxt        = ovf_r;
    out_load       = 1'b0;
    o_kind         = KIND_SEQ;
    o_byte         = 8'd0;
    o_last         = 1'b0;
    o_empty        = 1'b0;
    o_ovf          = 1'b0;
    push_en        = 1'b0;
    push_data      = in_data;
    seq_we         = 1'b0;
    seq_waddr      = seq_len_r[SAW-1:0];
    seq_wdata      = in_data;
    seq_re         = 1'b0;
    seq_raddr      = idx_r[SAW-1:0];
    fifo_re        = 1'b0;
    adv_one        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_ARM: begin
              // Arming discards any partial sequence.
              wanted_end_nxt = in_term_byte;
              phase_nxt      = PH_WAIT;
              seq_len_nxt    = '0;
              ovf_nxt        = 1'b0;
            end
            OP_BYTE: begin
              case (phase_r)
                PH_WAIT: begin
                  if (in_data == begin_mark_r) begin
                    phase_nxt   = PH_COLLECT;
                    seq_len_nxt = '0;
                    ovf_nxt     = 1'b0;
                  end else begin
                    push_en = 1'b1;
                    if (!fifo_full) begin
                      fifo_count_nxt = fifo_count_r + 1'b1;
                    end
                  end
                end
                PH_COLLECT: begin
                  if (in_data == wanted_end_r) begin
                    // End mark wins over begin mark when both match.
                    idx_nxt   = '0;
                    seq_raddr = '0;
                    if (seq_len_r == '0) begin
                      state_nxt = S_END_OUT;
                    end else begin
                      seq_re    = 1'b1;
                      state_nxt = S_EMIT_OUT;
                    end
                  end else if (in_data == begin_mark_r) begin
                    // Repeated begin: flush the partial sequence to the FIFO.
                    idx_nxt   = '0;
                    seq_raddr = '0;
                    if (seq_len_r == '0) begin
                      ovf_nxt = 1'b0;
                    end else begin
                      seq_re    = 1'b1;
                      state_nxt = S_FLUSH;
                    end
                  end else if (seq_len_r < SLW'(SEQ_DEPTH)) begin
                    seq_we      = 1'b1;
                    seq_len_nxt = seq_len_r + 1'b1;
                  end else begin
                    ovf_nxt = 1'b1;
                  end
                end
                default: begin
                  push_en = 1'b1;
                  if (!fifo_full) begin
                    fifo_count_nxt = fifo_count_r + 1'b1;
                  end
                end
              endcase
            end
            OP_POP: begin
              fifo_re   = 1'b1;
              state_nxt = S_POP_OUT;
            end
            default: ;
          endcase
        end
      end

      S_POP_OUT: begin
        adv_one = 1'b1;
        if (slot_free) begin
          out_load = 1'b1;
          o_kind   = KIND_POP;
          o_last   = 1'b1;
          if (fifo_count_r == '0) begin
            o_empty = 1'b1;
          end else begin
            o_byte         = fifo_rdata;
            fifo_head_nxt  = ptr_sum;
            fifo_count_nxt = fifo_count_r - 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_EMIT_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          o_byte   = seq_rdata;
          o_ovf    = ovf_r;
          idx_nxt  = idx_inc;
          if (idx_inc == seq_len_r) begin
            state_nxt = S_END_OUT;
          end else begin
            seq_re    = 1'b1;
            seq_raddr = idx_inc[SAW-1:0];
          end
        end
      end

      S_END_OUT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          o_byte      = wanted_end_r;
          o_last      = 1'b1;
          o_ovf       = ovf_r;
          phase_nxt   = PH_IDLE;
          seq_len_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end
      end

      S_FLUSH: begin
        push_en   = 1'b1;
        push_data = seq_rdata;
        if (!fifo_full) begin
          fifo_count_nxt = fifo_count_r + 1'b1;
        end
        idx_nxt = idx_inc;
        if (idx_inc == seq_len_r) begin
          seq_len_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = S_IDLE;
        end else begin
          seq_re    = 1'b1;
          seq_raddr = idx_inc[SAW-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_IDLE;
      fifo_head_r  <= '0;
      fifo_count_r <= '0;
      seq_len_r    <= '0;
      idx_r        <= '0;
      wanted_end_r <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      begin_mark_r <= BEGIN_MARK_RST;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      fifo_head_r  <= fifo_head_nxt;
      fifo_count_r <= fifo_count_nxt;
      seq_len_r    <= seq_len_nxt;
      idx_r        <= idx_nxt;
      wanted_end_r <= wanted_end_nxt;
      ovf_r        <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        begin_mark_r <= cfg_wr_data;
      end
    end
  end

  // Output payload: load only when a new item is produced.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= o_kind;
      out_byte_r  <= o_byte;
      out_last_r  <= o_last;
      out_empty_r <= o_empty;
      out_ovf_r   <= o_ovf;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_byte_out       = out_byte_r;
  assign out_last           = out_last_r;
  assign out_fifo_was_empty = out_empty_r;
  assign out_seq_overflow   = out_ovf_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count_r <= FCW'(FIFO_DEPTH))
    else $error("type-ahead count beyond FIFO depth");

  a_seq_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seq_len_r <= SLW'(SEQ_DEPTH))
    else $error("sequence length beyond store depth");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fifo_was_empty) |-> (out_byte_out == 8'd0 &&
      out_kind == KIND_POP && out_last && !out_seq_overflow))
    else $error("empty pop result carries data");

  a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_OUT && out_load && fifo_count_r != '0) |=>
      (fifo_count_r == $past(fifo_count_r) - 1'b1))
    else $error("pop did not consume one FIFO entry");

endmodule
`default_nettype wire

FILE: rtl/escseq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escseq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module escseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/escseq_wrap_add.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escseq_wrap_add
// Ring pointer adder: base plus offset, wrapped modulo DEPTH.
// ----------------------------------------------------------------------------
module escseq_wrap_add #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic [AW-1:0] base,
  input  wire logic [CW-1:0] offs,
  output logic      [AW-1:0] sum
);

  logic [CW:0] raw;
  logic [CW:0] wrapped;

  // Base is below DEPTH and the offset at most DEPTH, so the raw sum stays
  // below twice DEPTH and one compare and subtract is enough.
  always_comb begin
    raw     = (CW+1)'(base) + (CW+1)'(offs);
    wrapped = (raw >= (CW+1)'(DEPTH)) ? raw - (CW+1)'(DEPTH) : raw;
    sum     = wrapped[AW-1:0];
  end

endmodule
`default_nettype wire
